### design/chte_pkg.sv
// ----------------------------------------------------------------------------
// chte_pkg: shared types and constants of the chained hash table engine
// Field widths, operation and status codes, the hash constants, and the
// command bundle from the controller to the datapath.
// ----------------------------------------------------------------------------
package chte_pkg;

  localparam int CMD_W    = 2;
  localparam int KEY_W    = 16;
  localparam int VALUE_W  = 24;
  localparam int STATUS_W = 3;
  localparam int CNT_W    = 7;

  // One stored entry: key in the low bits, payload above it.
  localparam int ENTRY_W = KEY_W + VALUE_W;

  // Bucket hash is floor(key * 19 / 64), done exactly as (key * 19) >> 6.
  localparam int HASH_MUL    = 19;
  localparam int HASH_SHIFT  = 6;
  localparam int HASH_PROD_W = KEY_W + $clog2(HASH_MUL + 1);
  localparam int HASH_W      = HASH_PROD_W - HASH_SHIFT;
  localparam int CMP_W       = HASH_W + 1;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_UPDATED   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_DELETED   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd5;

  localparam logic [CNT_W-1:0] BUCKET_COUNT_RESET = 7'd64;

  // Register word index on the configuration port.
  localparam int REG_BUCKET_COUNT = 0;

  typedef struct packed {
    logic load;    // transaction accepted: latch it and read its bucket row
    logic commit;  // compare ways, write back an insert's row, load the result
  } chte_cmd_t;

endpackage

### design/chte_ram.sv
// ----------------------------------------------------------------------------
// chte_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered and holds
// while no read is issued.
// ----------------------------------------------------------------------------
module chte_ram #(
  parameter int WIDTH = 160,
  parameter int DEPTH = 64
) (
  input  logic                                     clk,
  input  logic                                     wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                         wr_data,
  input  logic                                     rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### design/chte_ctrl.sv
// ----------------------------------------------------------------------------
// chte_ctrl: operation sequencer
// Accepts one transaction, waits for its registered bucket row, then commits
// as soon as the result register is free.
// ----------------------------------------------------------------------------
module chte_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output chte_pkg::chte_cmd_t   cmd
);
  import chte_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_LOOKUP
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free  = !out_valid_r || out_tready;
  assign cmd.load   = (state_r == S_IDLE) && in_tvalid;
  assign cmd.commit = (state_r == S_LOOKUP) && slot_free;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        if (slot_free) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

endmodule

### design/chte_datapath.sv
// ----------------------------------------------------------------------------
// chte_datapath: hash, bucket row store and way compare
// Hashes the key, reads the bucket row, compares all ways in parallel,
// writes back the row and valid marks an insert or delete changed, and forms the result.
// ----------------------------------------------------------------------------
module chte_datapath #(
  parameter int NUM_BUCKETS = 64,
  parameter int CHAIN_DEPTH = 4
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  chte_pkg::chte_cmd_t                cmd,
  input  logic [chte_pkg::CNT_W-1:0]         bucket_count,
  input  logic [chte_pkg::CMD_W-1:0]         in_cmd,
  input  logic [chte_pkg::KEY_W-1:0]         in_key,
  input  logic [chte_pkg::VALUE_W-1:0]       in_value,
  output logic [chte_pkg::STATUS_W-1:0]      out_status,
  output logic                               out_found,
  output logic [chte_pkg::VALUE_W-1:0]       out_value
);
  import chte_pkg::*;

  localparam int BW    = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int WW    = (CHAIN_DEPTH > 1) ? $clog2(CHAIN_DEPTH) : 1;
  localparam int ROW_W = CHAIN_DEPTH * ENTRY_W;

  // Hash and clamp of the incoming key.
  logic [HASH_PROD_W-1:0] prod;
  logic [CMP_W-1:0]       hash_ext, cnt_ext, used, bucket_sel;
  logic [BW-1:0]          bucket_in;

  assign prod     = HASH_PROD_W'(in_key) * HASH_PROD_W'(HASH_MUL);
  assign hash_ext = CMP_W'(prod[HASH_PROD_W-1:HASH_SHIFT]);
  assign cnt_ext  = CMP_W'(bucket_count);

  always_comb begin
    if (cnt_ext == '0) begin
      used = CMP_W'(1);
    end else if (cnt_ext > CMP_W'(NUM_BUCKETS)) begin
      used = CMP_W'(NUM_BUCKETS);
    end else begin
      used = cnt_ext;
    end
    bucket_sel = (hash_ext >= used) ? (used - CMP_W'(1)) : hash_ext;
  end

  assign bucket_in = bucket_sel[BW-1:0];

  // Latched operation.
  logic [CMD_W-1:0]   cmd_r;
  logic [KEY_W-1:0]   key_r;
  logic [VALUE_W-1:0] value_r;
  logic [BW-1:0]      bucket_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r    <= in_cmd;
      key_r    <= in_key;
      value_r  <= in_value;
      bucket_r <= bucket_in;
    end
  end

  // Valid marks live in flops so that reset empties the table at once.
  logic [NUM_BUCKETS-1:0][CHAIN_DEPTH-1:0] valid_r;
  logic [CHAIN_DEPTH-1:0] row_valid, row_valid_nxt;
  logic [ROW_W-1:0]       rd_row, wr_row;
  logic                   wr_en;

  assign row_valid = valid_r[bucket_r];

  chte_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NUM_BUCKETS)
  ) u_row_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (bucket_r),
    .wr_data (wr_row),
    .rd_en   (cmd.load),
    .rd_addr (bucket_in),
    .rd_data (rd_row)
  );

  // Parallel compare: lowest matching way and lowest free way.
  logic          hit_any, free_any;
  logic [WW-1:0] hit_way, free_way, tgt_way;

  always_comb begin
    hit_any  = 1'b0;
    free_any = 1'b0;
    hit_way  = '0;
    free_way = '0;
    for (int w = 0; w < CHAIN_DEPTH; w++) begin
      if (row_valid[w] && (rd_row[w*ENTRY_W +: KEY_W] == key_r) && !hit_any) begin
        hit_any = 1'b1;
        hit_way = WW'(w);
      end
      if (!row_valid[w] && !free_any) begin
        free_any = 1'b1;
        free_way = WW'(w);
      end
    end
  end

  logic               is_insert, is_search, is_delete;
  logic [STATUS_W-1:0] status_nxt;
  logic               found_nxt;
  logic [VALUE_W-1:0] value_nxt;

  assign is_insert = (cmd_r == CMD_INSERT);
  assign is_search = (cmd_r == CMD_SEARCH);
  assign is_delete = (cmd_r == CMD_DELETE);
  assign tgt_way   = hit_any ? hit_way : free_way;

  always_comb begin
    status_nxt    = ST_NOT_FOUND;
    found_nxt     = 1'b0;
    value_nxt     = '0;
    row_valid_nxt = row_valid;
    wr_en         = 1'b0;
    if (is_insert) begin
      if (hit_any) begin
        status_nxt = ST_UPDATED;
        found_nxt  = 1'b1;
        wr_en      = cmd.commit;
      end else if (free_any) begin
        status_nxt              = ST_INSERTED;
        row_valid_nxt[free_way] = 1'b1;
        wr_en                   = cmd.commit;
      end else begin
        status_nxt = ST_FULL;
      end
    end else if (is_search) begin
      if (hit_any) begin
        status_nxt = ST_FOUND;
        found_nxt  = 1'b1;
        value_nxt  = rd_row[hit_way*ENTRY_W + KEY_W +: VALUE_W];
      end
    end else if (is_delete) begin
      if (hit_any) begin
        status_nxt             = ST_DELETED;
        found_nxt              = 1'b1;
        row_valid_nxt[hit_way] = 1'b0;
      end
    end
  end

  // Row written back: the target way takes the key and the new payload.
  always_comb begin
    wr_row = rd_row;
    for (int w = 0; w < CHAIN_DEPTH; w++) begin
      if (tgt_way == WW'(w)) begin
        wr_row[w*ENTRY_W +: ENTRY_W] = {value_r, key_r};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.commit) begin
      valid_r[bucket_r] <= row_valid_nxt;
    end
  end

  logic [STATUS_W-1:0] status_r;
  logic                found_r;
  logic [VALUE_W-1:0]  value_out_r;

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status_r    <= status_nxt;
      found_r     <= found_nxt;
      value_out_r <= value_nxt;
    end
  end

  assign out_status = status_r;
  assign out_found  = found_r;
  assign out_value  = value_out_r;

endmodule

### design/chained_hash_table_engine.sv
// ----------------------------------------------------------------------------
// chained_hash_table_engine: key/value hash table with bounded chains
// Insert-or-update, search and delete over NUM_BUCKETS buckets of
// CHAIN_DEPTH ways each, bucket chosen by (key * 19) >> 6 and clamped to bucket_count.
//
//   Channel  Direction  Handshake             Content
//   in_      slave      tvalid/tready         cmd, key, value
//   out_     master     tvalid/tready         status, found, value_out
//   cfg_     APB slave  psel/penable/pready   bucket_count at address 0
//
// Each operation has two phases: the accept reads the bucket row from the row
// RAM, the lookup state compares its ways and writes an insert's row back
// through the same RAM, so no new operation is accepted until the last commits.
// Reset clears the valid marks at once; no clearing pass is needed.
// A result waiting in the output register does not block the next accept;
// the following commit waits until that register is taken.
// ----------------------------------------------------------------------------
module chained_hash_table_engine #(
  parameter int NUM_BUCKETS = 64,
  parameter int CHAIN_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,    // cmd[1:0], key[17:2], value[41:18], zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,   // status[2:0], found[3], value_out[27:4], zero pad
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import chte_pkg::*;

  // Configuration register.
  logic [CNT_W-1:0] bucket_count_r;
  logic             cfg_write;
  logic             cfg_hit;

  assign cfg_pready = 1'b1;
  assign cfg_hit    = (cfg_paddr == 2'(REG_BUCKET_COUNT * 4));
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bucket_count_r <= BUCKET_COUNT_RESET;
    end else if (cfg_write && cfg_hit) begin
      bucket_count_r <= cfg_pwdata[CNT_W-1:0];
    end
  end

  assign cfg_prdata = cfg_hit ? 32'(bucket_count_r) : '0;

  chte_cmd_t           dp_cmd;
  logic [STATUS_W-1:0] res_status;
  logic                res_found;
  logic [VALUE_W-1:0]  res_value;

  chte_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (dp_cmd)
  );

  chte_datapath #(
    .NUM_BUCKETS (NUM_BUCKETS),
    .CHAIN_DEPTH (CHAIN_DEPTH)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (dp_cmd),
    .bucket_count (bucket_count_r),
    .in_cmd       (in_tdata[CMD_W-1:0]),
    .in_key       (in_tdata[CMD_W +: KEY_W]),
    .in_value     (in_tdata[CMD_W + KEY_W +: VALUE_W]),
    .out_status   (res_status),
    .out_found    (res_found),
    .out_value    (res_value)
  );

  assign out_tdata = {4'b0, res_value, res_found, res_status};

`ifndef NO_ASSERTIONS
  // After an accept the engine is busy with the lookup in the next cycle.
  a_accept_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted on two consecutive cycles");

  // A commit never overwrites a result that has not been taken.
  a_commit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.commit |-> (!out_tvalid || out_tready))
    else $error("commit while output register still holds a result");

  // Every commit presents a result on the next cycle.
  a_commit_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.commit |=> out_tvalid)
    else $error("commit did not produce a result");

  // Load and commit belong to different phases of an operation.
  a_load_commit_apart: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.load |-> !dp_cmd.commit)
    else $error("load and commit in the same cycle");
`endif

endmodule

### tb/chained_hash_table_engine_tb.sv
// ----------------------------------------------------------------------------
// chained_hash_table_engine_tb: self-checking bench for the hash table engine
// A clocked driver sends insert, search, delete and unused-command transactions
// from a queue and a clocked monitor checks every result against a predictor that
// keeps its own copy of the bucket store and the bucket count register.
// ----------------------------------------------------------------------------
module chained_hash_table_engine_tb;
  import chte_pkg::*;

  localparam int NUM_BUCKETS = 64;
  localparam int CHAIN_DEPTH = 4;
  localparam int STORE_SIZE  = NUM_BUCKETS * CHAIN_DEPTH;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_OPS   = 175;

  // Command code three has no meaning in the block; it must change nothing.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
  } table_op_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                found;
    logic [VALUE_W-1:0]  value_out;
  } table_reply_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;     // cmd[1:0], key[17:2], value[41:18], zero pad
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;         // status[2:0], found[3], value_out[27:4], zero pad
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [1:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // Predicted state of the block.
  logic                entry_valid [STORE_SIZE];
  logic [KEY_W-1:0]    entry_key   [STORE_SIZE];
  logic [VALUE_W-1:0]  entry_value [STORE_SIZE];
  logic [CNT_W-1:0]    bucket_cnt;

  table_op_t    pending_ops[$];
  table_reply_t expected_replies[$];
  table_op_t    send_op;
  int           send_gap = 0;
  int           send_idle_pct = 25;
  int           recv_gap = 0;
  int           recv_idle_pct = 25;
  int           hold_cnt = 0;
  bit           hold_go = 1'b0;
  bit           hold_done = 1'b0;
  int           errors = 0;

  chained_hash_table_engine #(
    .NUM_BUCKETS(NUM_BUCKETS),
    .CHAIN_DEPTH(CHAIN_DEPTH)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #5 clk = ~clk;

  // Applies one operation to the predicted table and returns its reply.
  function automatic table_reply_t hash_table_apply(table_op_t op);
    int used;
    int bucket;
    int base;
    int hit;
    int free_way;
    table_reply_t r;
    used = int'(bucket_cnt);
    if (used == 0) used = 1;
    if (used > NUM_BUCKETS) used = NUM_BUCKETS;
    bucket = (int'(op.key) * HASH_MUL) >> HASH_SHIFT;
    if (bucket >= used) bucket = used - 1;
    base = bucket * CHAIN_DEPTH;
    hit = -1;
    free_way = -1;
    for (int w = 0; w < CHAIN_DEPTH; w++) begin
      if (entry_valid[base + w]) begin
        if (hit < 0 && entry_key[base + w] == op.key) hit = w;
      end else if (free_way < 0) begin
        free_way = w;
      end
    end
    r.status = ST_NOT_FOUND;
    r.found = 1'b0;
    r.value_out = '0;
    case (op.cmd)
      CMD_INSERT: begin
        if (hit >= 0) begin
          entry_value[base + hit] = op.value;
          r.status = ST_UPDATED;
          r.found = 1'b1;
        end else if (free_way >= 0) begin
          entry_valid[base + free_way] = 1'b1;
          entry_key[base + free_way] = op.key;
          entry_value[base + free_way] = op.value;
          r.status = ST_INSERTED;
        end else begin
          r.status = ST_FULL;
        end
      end
      CMD_SEARCH: begin
        if (hit >= 0) begin
          r.status = ST_FOUND;
          r.found = 1'b1;
          r.value_out = entry_value[base + hit];
        end
      end
      CMD_DELETE: begin
        if (hit >= 0) begin
          entry_valid[base + hit] = 1'b0;
          r.status = ST_DELETED;
          r.found = 1'b1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Driver: offers queued operations, predicting each one as it is accepted.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_tvalid && in_tready)
        expected_replies.push_back(hash_table_apply(send_op));
      if (!in_tvalid || in_tready) begin
        if (send_gap == 0 && send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
          send_gap = $urandom_range(4, 1);
        if (send_gap > 0) begin
          send_gap--;
          in_tvalid <= 1'b0;
        end else if (pending_ops.size() > 0) begin
          send_op = pending_ops.pop_front();
          in_tdata <= {6'b0, send_op.value, send_op.key, send_op.cmd};
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted in cycles once it has been requested.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_cnt <= 0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
    end else if (hold_go && !hold_done) begin
      hold_cnt <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  // Monitor: checks each result transaction and paces out_tready.
  always @(posedge clk) begin
    table_reply_t exp_r;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_replies.size() == 0) begin
          $error("unexpected result transaction: out_tdata %h", out_tdata);
          errors++;
        end else begin
          exp_r = expected_replies.pop_front();
          if (out_tdata[2:0] !== exp_r.status) begin
            $error("status: expected %0d, actual %0d", exp_r.status, out_tdata[2:0]);
            errors++;
          end
          if (out_tdata[3] !== exp_r.found) begin
            $error("found: expected %0d, actual %0d", exp_r.found, out_tdata[3]);
            errors++;
          end
          if (out_tdata[27:4] !== exp_r.value_out) begin
            $error("value_out: expected %h, actual %h", exp_r.value_out, out_tdata[27:4]);
            errors++;
          end
          if (out_tdata[31:28] !== 4'b0) begin
            $error("pad: expected 0, actual %h", out_tdata[31:28]);
            errors++;
          end
        end
      end
      if (hold_cnt == 0 && recv_gap == 0 && recv_idle_pct != 0 &&
          $urandom_range(99) < recv_idle_pct)
        recv_gap = $urandom_range(4, 1);
      if (hold_cnt > 0) begin
        out_tready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  function automatic table_op_t make_op(logic [CMD_W-1:0] cmd, int key, int value);
    table_op_t op;
    op.cmd = cmd;
    op.key = KEY_W'(key);
    op.value = VALUE_W'(value);
    return op;
  endfunction

  // Keys that land in few buckets, so chains fill up and collide often.
  function automatic logic [KEY_W-1:0] pick_key(int bc);
    int b;
    case ($urandom_range(3))
      0, 1: return KEY_W'($urandom_range(60));
      2: begin
        b = $urandom_range((bc > NUM_BUCKETS) ? NUM_BUCKETS : bc);
        return KEY_W'((b * 64) / 19 + $urandom_range(3));
      end
      default: return KEY_W'($urandom());
    endcase
  endfunction

  task automatic add_random_ops(int n, int bc);
    logic [KEY_W-1:0] pool [10];
    table_op_t op;
    int r;
    foreach (pool[i]) pool[i] = pick_key(bc);
    for (int i = 0; i < n; i++) begin
      op.key = ($urandom_range(99) < 85) ? pool[$urandom_range(9)] : KEY_W'($urandom());
      r = $urandom_range(99);
      if (r < 40) op.cmd = CMD_INSERT;
      else if (r < 70) op.cmd = CMD_SEARCH;
      else if (r < 95) op.cmd = CMD_DELETE;
      else op.cmd = CMD_UNUSED;
      op.value = VALUE_W'($urandom());
      pending_ops.push_back(op);
    end
  endtask

  task automatic wait_idle();
    while (pending_ops.size() != 0 || in_tvalid || expected_replies.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes the bucket count register, then reads it back.
  task automatic set_bucket_count(int bc);
    logic [31:0] wdata;
    wdata = ($urandom() & ~32'h7F) | 32'(bc);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= 2'(4 * REG_BUCKET_COUNT);
    cfg_pwdata <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    bucket_cnt = wdata[CNT_W-1:0];
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== 32'(bucket_cnt)) begin
      $error("bucket_count readback: expected %0d, actual %0d", bucket_cnt, cfg_prdata);
      errors++;
    end
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int settings [9];
    foreach (entry_valid[i]) begin
      entry_valid[i] = 1'b0;
      entry_key[i] = '0;
      entry_value[i] = '0;
    end
    bucket_cnt = BUCKET_COUNT_RESET;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, at the reset bucket count. Keys 0 to 3 share bucket 0;
    // every key from 213 up lands in the last bucket, from 216 up by the clamp.
    pending_ops.push_back(make_op(CMD_SEARCH, 0, 0));
    pending_ops.push_back(make_op(CMD_DELETE, 0, 0));
    pending_ops.push_back(make_op(CMD_INSERT, 0, 24'h000000));
    pending_ops.push_back(make_op(CMD_INSERT, 1, 24'hFFFFFF));
    pending_ops.push_back(make_op(CMD_INSERT, 2, 24'h123456));
    pending_ops.push_back(make_op(CMD_INSERT, 3, 24'hAAAAAA));
    pending_ops.push_back(make_op(CMD_INSERT, 0, 24'h555555));
    pending_ops.push_back(make_op(CMD_INSERT, 65535, 24'h0F0F0F));
    pending_ops.push_back(make_op(CMD_INSERT, 65534, 24'hF0F0F0));
    pending_ops.push_back(make_op(CMD_INSERT, 1000, 24'h800001));
    pending_ops.push_back(make_op(CMD_INSERT, 213, 24'h7FFFFE));
    pending_ops.push_back(make_op(CMD_INSERT, 300, 24'h333333));
    pending_ops.push_back(make_op(CMD_SEARCH, 65535, 0));
    pending_ops.push_back(make_op(CMD_DELETE, 213, 0));
    pending_ops.push_back(make_op(CMD_INSERT, 300, 24'h333333));
    pending_ops.push_back(make_op(CMD_SEARCH, 212, 0));
    pending_ops.push_back(make_op(CMD_UNUSED, 0, 24'hFFFFFF));
    pending_ops.push_back(make_op(CMD_SEARCH, 0, 0));
    pending_ops.push_back(make_op(CMD_DELETE, 0, 0));
    pending_ops.push_back(make_op(CMD_SEARCH, 0, 0));
    pending_ops.push_back(make_op(CMD_SEARCH, 1, 0));
    pending_ops.push_back(make_op(CMD_INSERT, 4, 24'hC3C3C3));
    pending_ops.push_back(make_op(CMD_SEARCH, 300, 0));
    wait_idle();

    // Bucket count settings per phase; zero and values above the bucket
    // total are clamped by the block, and stored entries stay in place.
    settings = '{1, 64, 0, 127, 2, $urandom_range(64, 1), 33, $urandom_range(127), 64};
    foreach (settings[p]) begin
      set_bucket_count(settings[p]);
      send_idle_pct = (p % 2 == 0) ? 25 : 0;
      recv_idle_pct = (p % 3 == 2) ? 0 : 25;
      if (p == 1) begin
        // Long receiver hold-off while the sender keeps pushing.
        send_idle_pct = 0;
        hold_go = 1'b1;
      end
      if (p == $size(settings) - 1) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      add_random_ops(PHASE_OPS, settings[p]);
      wait_idle();
    end

    repeat (16) @(posedge clk);
    if (errors == 0) begin
      $display("chained_hash_table_engine_tb: clean");
    end else begin
      $display("chained_hash_table_engine_tb: errors");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("chained_hash_table_engine_tb: errors");
    $finish;
  end

endmodule

### files.f
design/chte_pkg.sv
design/chte_ram.sv
design/chte_ctrl.sv
design/chte_datapath.sv
design/chained_hash_table_engine.sv
tb/chained_hash_table_engine_tb.sv
